@@ rtl/mcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants for the minimum sphere-set clearance core.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int MAX_SET_A_DEF = 64;
  localparam int POS_W    = 24;
  localparam int RAD_W    = 16;
  localparam int CLR_W    = 27;
  localparam int ROOT_W   = 25;
  localparam int SQ_W     = 2 * ROOT_W;
  localparam int RSUM_W   = RAD_W + 1;
  localparam int ENTRY_W  = 3 * POS_W + RAD_W;

  localparam logic signed [CLR_W-1:0] MIN_POS_MAX = {1'b0, {(CLR_W-1){1'b1}}};

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_SET_B  = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [RAD_W-1:0]        radius;
    logic                    last_b;
  } in_t;

  typedef struct packed {
    logic signed [CLR_W-1:0] min_clearance;
    logic                    has_pairs;
    logic                    set_a_overflowed;
  } out_t;

endpackage

@@ rtl/mcc_ram.sv @@
// ----------------------------------------------------------------------------
// mcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mcc_isqrt.sv @@
// ----------------------------------------------------------------------------
// mcc_isqrt
// Pipelined floor integer square root, one result bit per stage, with a
// sideband tag carried alongside.
// ----------------------------------------------------------------------------
module mcc_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [mcc_pkg::SQ_W-1:0]        in_n,
  input  logic [TAG_W-1:0]                in_tag,
  output logic                            out_vld,
  output logic [mcc_pkg::ROOT_W-1:0]      out_root,
  output logic [TAG_W-1:0]                out_tag
);

  localparam int RW  = mcc_pkg::ROOT_W;
  localparam int NW  = mcc_pkg::SQ_W;
  localparam int REMW = RW + 1;

  logic [NW-1:0]   n_r    [RW];
  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [TAG_W-1:0] tag_r [RW];
  logic [RW-1:0]   vld_r;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [NW-1:0]   n_p;
    logic [REMW-1:0] rem_p;
    logic [RW-1:0]   root_p;
    logic [TAG_W-1:0] tag_p;
    logic            vld_p;
    logic [REMW+1:0] rs;
    logic [REMW+1:0] trial;
    logic            take;

    if (s == 0) begin : g_first
      assign n_p    = in_n;
      assign rem_p  = '0;
      assign root_p = '0;
      assign tag_p  = in_tag;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign n_p    = n_r[s-1];
      assign rem_p  = rem_r[s-1];
      assign root_p = root_r[s-1];
      assign tag_p  = tag_r[s-1];
      assign vld_p  = vld_r[s-1];
    end

    // bring down two bits, try subtracting 4*root+1
    assign rs    = {rem_p, n_p[NW-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign take  = (rs >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      n_r[s]    <= {n_p[NW-3:0], 2'b00};
      rem_r[s]  <= take ? rs[REMW-1:0] - trial[REMW-1:0] : rs[REMW-1:0];
      root_r[s] <= {root_p[RW-2:0], take};
      tag_r[s]  <= tag_p;
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_tag  = tag_r[RW-1];

endmodule

@@ rtl/min_clearance_two_point_sets_core.sv @@
// ----------------------------------------------------------------------------
// min_clearance_two_point_sets_core
// Smallest surface clearance between two sets of spheres, Q12 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the transfer happens on a rising
//   edge with start high and busy low. Clear and append requests leave
//   busy low. A set-B sphere raises busy while it is compared with the
//   stored set-A spheres.
//   Set A lives in one RAM (one entry per sphere). A set-B sphere issues one
//   RAM read per stored sphere per cycle into a distance pipeline (diff,
//   square, sum, 25-stage root, clearance, minimum), then drains it.
//   A set-B item holds busy high through its scan and drain; the next transfer
//   can follow on the edge that ends the first cycle with busy low.
//   Output: on a set-B sphere marked last, out_valid pulses for one cycle
//   with out_data in the cycle busy falls; the receiver cannot stall and
//   the result is simply taken on that edge.
//   Reset: set A empty, running minimum most positive, flags cleared. No
//   clearing pass is needed; entries at or beyond count_a are never used.
// ----------------------------------------------------------------------------
module min_clearance_two_point_sets_core #(
  parameter int MAX_SET_A = mcc_pkg::MAX_SET_A_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mcc_pkg::in_t   in_data,
  output logic           out_valid,
  output mcc_pkg::out_t  out_data
);

  localparam int AW    = (MAX_SET_A > 1) ? $clog2(MAX_SET_A) : 1;
  localparam int CW    = $clog2(MAX_SET_A + 1);
  localparam int POS_W = mcc_pkg::POS_W;
  localparam int RAD_W = mcc_pkg::RAD_W;
  localparam int CLR_W = mcc_pkg::CLR_W;
  localparam int RSUM_W = mcc_pkg::RSUM_W;
  localparam int DRAIN_CYC = mcc_pkg::ROOT_W + 8;
  localparam int DW    = $clog2(DRAIN_CYC + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_a_r;
  logic [CW-1:0] idx_r;
  logic [DW-1:0] drain_r;
  logic          overflow_r;
  logic          pair_seen_r;
  logic signed [CLR_W-1:0] run_min_r;

  logic signed [POS_W-1:0] bx_r, by_r, bz_r;
  logic [RAD_W-1:0]        br_r;
  logic                    last_r;

  logic accept, issue;
  logic [mcc_pkg::ENTRY_W-1:0] wdata, rdata;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign issue  = (state_r == ST_SCAN) && (idx_r != count_a_r);

  // set-A sphere store
  assign wdata = {in_data.pos_x, in_data.pos_y, in_data.pos_z, in_data.radius};

  mcc_ram #(
    .WIDTH (mcc_pkg::ENTRY_W),
    .DEPTH (MAX_SET_A)
  ) u_store (
    .clk   (clk),
    .we    (accept && in_data.req_type == mcc_pkg::REQ_APPEND &&
            count_a_r != CW'(MAX_SET_A)),
    .waddr (count_a_r[AW-1:0]),
    .wdata (wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && in_data.req_type == mcc_pkg::REQ_SET_B) state_nxt = ST_SCAN;
      ST_SCAN:  if (!issue) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == '0) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_a_r  <= '0;
      overflow_r <= 1'b0;
      idx_r      <= '0;
      drain_r    <= '0;
    end else begin
      state_r <= state_nxt;
      // clear and append requests
      if (accept && in_data.req_type == mcc_pkg::REQ_CLEAR) begin
        count_a_r  <= '0;
        overflow_r <= 1'b0;
      end else if (accept && in_data.req_type == mcc_pkg::REQ_APPEND) begin
        if (count_a_r != CW'(MAX_SET_A)) begin
          count_a_r <= count_a_r + 1'b1;
        end else begin
          overflow_r <= 1'b1;
        end
      end
      // clear read index on accept, advance it during scan
      if (accept) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      // load drain counter during scan, then count down until the pipeline is empty
      if (state_r == ST_SCAN) begin
        drain_r <= DW'(DRAIN_CYC);
      end else if (state_r == ST_DRAIN && drain_r != '0) begin
        drain_r <= drain_r - 1'b1;
      end
    end
  end

  // capture the sphere of every accepted request (used for set-B)
  always_ff @(posedge clk) begin
    if (accept) begin
      bx_r   <= in_data.pos_x;
      by_r   <= in_data.pos_y;
      bz_r   <= in_data.pos_z;
      br_r   <= in_data.radius;
      last_r <= in_data.last_b;
    end
  end

  // distance pipeline: read, diff, square, sum
  logic v1_r, v2_r, v3_r, v4_r;
  logic [POS_W-1:0]  dx_r, dy_r, dz_r;
  logic [2*POS_W-1:0] sx_r, sy_r, sz_r;
  logic [mcc_pkg::SQ_W-1:0] sum_r;
  logic [RSUM_W-1:0] rs2_r, rs3_r, rs4_r;

  logic signed [POS_W:0] ddx, ddy, ddz;
  logic [POS_W-1:0] ax, ay, az;
  logic [RAD_W-1:0] ar;

  assign ax = rdata[mcc_pkg::ENTRY_W-1 -: POS_W];
  assign ay = rdata[RAD_W+2*POS_W-1 -: POS_W];
  assign az = rdata[RAD_W+POS_W-1 -: POS_W];
  assign ar = rdata[RAD_W-1:0];

  assign ddx = $signed({ax[POS_W-1], ax}) - $signed({bx_r[POS_W-1], bx_r});
  assign ddy = $signed({ay[POS_W-1], ay}) - $signed({by_r[POS_W-1], by_r});
  assign ddz = $signed({az[POS_W-1], az}) - $signed({bz_r[POS_W-1], bz_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= ddx[POS_W] ? POS_W'(-ddx) : ddx[POS_W-1:0];
    dy_r  <= ddy[POS_W] ? POS_W'(-ddy) : ddy[POS_W-1:0];
    dz_r  <= ddz[POS_W] ? POS_W'(-ddz) : ddz[POS_W-1:0];
    rs2_r <= RSUM_W'(ar) + RSUM_W'(br_r);
    sx_r  <= dx_r * dx_r;
    sy_r  <= dy_r * dy_r;
    sz_r  <= dz_r * dz_r;
    rs3_r <= rs2_r;
    sum_r <= mcc_pkg::SQ_W'(sx_r) + mcc_pkg::SQ_W'(sy_r) + mcc_pkg::SQ_W'(sz_r);
    rs4_r <= rs3_r;
  end

  // square root
  logic                      rt_vld;
  logic [mcc_pkg::ROOT_W-1:0] rt_root;
  logic [RSUM_W-1:0]         rt_rsum;

  mcc_isqrt #(
    .TAG_W (RSUM_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_n     (sum_r),
    .in_tag   (rs4_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_tag  (rt_rsum)
  );

  // clearance and running minimum
  logic                    c_vld_r;
  logic signed [CLR_W-1:0] clr_r;

  always_ff @(posedge clk) begin
    clr_r <= $signed(CLR_W'(rt_root)) - $signed(CLR_W'(rt_rsum));
  end

  logic emit;
  assign emit = (state_r == ST_DRAIN) && (drain_r == '0) && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r     <= 1'b0;
      run_min_r   <= mcc_pkg::MIN_POS_MAX;
      pair_seen_r <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      c_vld_r   <= rt_vld;
      out_valid <= emit;
      if (emit) begin
        run_min_r   <= mcc_pkg::MIN_POS_MAX;
        pair_seen_r <= 1'b0;
      end else if (c_vld_r) begin
        if (clr_r < run_min_r) begin
          run_min_r <= clr_r;
        end
        pair_seen_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.min_clearance    <= run_min_r;
      out_data.has_pairs        <= pair_seen_r;
      out_data.set_a_overflowed <= overflow_r;
    end
  end

`ifndef SYNTHESIS
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a set-B item in progress");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_a_r <= CW'(MAX_SET_A))
    else $error("set-A count beyond capacity");

  a_no_pairs_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_pairs) |-> out_data.min_clearance == mcc_pkg::MIN_POS_MAX)
    else $error("empty result carries a clearance");
`endif

endmodule
